[design/kese_pkg.sv]
// Package for the key escape sequence encoder.
// Holds key codes, byte constants, the sequence descriptor type and the F-key tables.
// No dependencies.
package kese_pkg;

  localparam int unsigned KESE_QUEUE_DEPTH = 2;
  localparam int unsigned KESE_MAX_BYTES   = 6;

  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_PGUP  = 8'h21;
  localparam logic [7:0] KEY_PGDN  = 8'h22;
  localparam logic [7:0] KEY_END   = 8'h23;
  localparam logic [7:0] KEY_HOME  = 8'h24;
  localparam logic [7:0] KEY_LEFT  = 8'h25;
  localparam logic [7:0] KEY_UP    = 8'h26;
  localparam logic [7:0] KEY_RIGHT = 8'h27;
  localparam logic [7:0] KEY_DOWN  = 8'h28;
  localparam logic [7:0] KEY_INS   = 8'h2D;
  localparam logic [7:0] KEY_DEL   = 8'h2E;
  localparam logic [7:0] KEY_F1    = 8'h70;
  localparam logic [7:0] KEY_F12   = 8'h7B;
  localparam logic [7:0] KEY_LBRK  = 8'hDB;
  localparam logic [7:0] KEY_A     = 8'h41;
  localparam logic [7:0] KEY_Z     = 8'h5A;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CTRL_BASE = 8'h40;
  localparam logic [7:0] CASE_DIFF = 8'd32;

  typedef logic [2:0] seq_len_t;

  typedef struct packed {
    logic [KESE_MAX_BYTES-1:0][7:0] data;
    seq_len_t                       len;
  } seq_t;

  function automatic logic [7:0] fkey_hi(input logic [2:0] idx);
    fkey_hi = idx[2] ? 8'h32 : 8'h31;
  endfunction

  function automatic logic [7:0] fkey_lo(input logic [2:0] idx);
    logic [7:0] res;
    case (idx)
      3'd0:    res = 8'h35;
      3'd1:    res = 8'h37;
      3'd2:    res = 8'h38;
      3'd3:    res = 8'h39;
      3'd4:    res = 8'h30;
      3'd5:    res = 8'h31;
      3'd6:    res = 8'h33;
      default: res = 8'h34;
    endcase
    fkey_lo = res;
  endfunction

endpackage

[design/kese_if.sv]
// Channel interfaces for the key escape sequence encoder.
// Depends on nothing; key events in, sequence bytes out.
interface kese_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic       shift_held;
  logic       ctrl_held;
  logic       alt_held;

  modport source (output valid, key_code, shift_held, ctrl_held, alt_held, input ready);
  modport sink   (input valid, key_code, shift_held, ctrl_held, alt_held, output ready);
endinterface

interface kese_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

[design/key_escape_sequence_encoder.sv]
// Top level of the key escape sequence encoder: front end, descriptor queue, back end.
// Depends on kese_pkg, kese_if, kese_front, kese_queue and kese_back.
//
//   port    dir  payload                                          role
//   key_i   in   key_code[7:0] shift_held ctrl_held alt_held      one key-down event
//   byte_o  out  out_byte[7:0] last_byte                          one sequence byte
//
// A key is classified and written into the queue when it is taken; an idle back end then loads
// it from the queue into its byte register, and its first byte is offered from that register.
// The back end sends one byte per cycle while byte_o is ready; a key's sequence has 1 to 6 bytes.
// key_i stays ready while the queue has room, also while byte_o is stalled.
// Keys that produce no bytes are taken and dropped.
// Reset clears the queue and the byte counter; no clearing pass is needed.
module key_escape_sequence_encoder
  import kese_pkg::*;
#(
  parameter int unsigned QueueDepth = KESE_QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kese_key_if.sink     key_i,
  kese_byte_if.source  byte_o
);

  logic push;
  logic full;
  logic pop;
  logic empty;
  seq_t push_seq;
  seq_t pop_seq;

  kese_front u_front (
    .key_i  (key_i),
    .full_i (full),
    .push_o (push),
    .seq_o  (push_seq)
  );

  kese_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_seq_i (push_seq),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_seq_o  (pop_seq)
  );

  kese_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .seq_i   (pop_seq),
    .pop_o   (pop),
    .byte_o  (byte_o)
  );

endmodule

[design/kese_front.sv]
// Front end: accepts key events and classifies them into a byte sequence descriptor.
// Depends on kese_pkg and kese_if; feeds kese_queue.
module kese_front
  import kese_pkg::*;
(
  kese_key_if.sink key_i,
  input  logic     full_i,
  output logic     push_o,
  output seq_t     seq_o
);

  function automatic seq_t encode(input logic [7:0] key, input logic shift,
                                  input logic ctrl, input logic alt);
    seq_t       s;
    logic       letter;
    logic [3:0] m;
    logic [7:0] fin;
    logic [7:0] digit;
    logic [3:0] f;
    s      = '0;
    letter = (key >= KEY_A) && (key <= KEY_Z);
    m      = 4'd1 + {3'd0, shift} + {2'd0, alt, 1'b0} + {1'b0, ctrl, 2'd0};
    digit  = CH_ZERO + {4'd0, m};
    fin    = 8'h00;
    f      = 4'(key - KEY_F1);
    if (ctrl && !alt && letter) begin
      s.data[0] = key - CTRL_BASE;
      s.len     = 3'd1;
    end else if (ctrl && !alt && key == KEY_LBRK) begin
      s.data[0] = CH_ESC;
      s.len     = 3'd1;
    end else if (alt && !ctrl && letter) begin
      s.data[0] = CH_ESC;
      s.data[1] = shift ? key : key + CASE_DIFF;
      s.len     = 3'd2;
    end else begin
      unique case (key)
        KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT, KEY_HOME, KEY_END: begin
          case (key)
            KEY_UP:    fin = 8'h41;
            KEY_DOWN:  fin = 8'h42;
            KEY_RIGHT: fin = 8'h43;
            KEY_LEFT:  fin = 8'h44;
            KEY_HOME:  fin = 8'h48;
            default:   fin = 8'h46;
          endcase
          s.data[0] = CH_ESC;
          s.data[1] = CH_LBRK;
          if (m > 4'd1) begin
            s.data[2] = CH_ONE;
            s.data[3] = CH_SEMI;
            s.data[4] = digit;
            s.data[5] = fin;
            s.len     = 3'd6;
          end else begin
            s.data[2] = fin;
            s.len     = 3'd3;
          end
        end
        KEY_INS, KEY_DEL, KEY_PGUP, KEY_PGDN: begin
          s.data[0] = CH_ESC;
          s.data[1] = CH_LBRK;
          s.data[2] = (key == KEY_INS) ? 8'h32 : (key == KEY_DEL) ? 8'h33
                    : (key == KEY_PGUP) ? 8'h35 : 8'h36;
          s.data[3] = CH_TILDE;
          s.len     = 3'd4;
        end
        KEY_ESC: begin
          s.data[0] = CH_ESC;
          s.len     = 3'd1;
        end
        KEY_TAB: begin
          if (shift) begin
            s.data[0] = CH_ESC;
            s.data[1] = CH_LBRK;
            s.data[2] = CH_Z;
            s.len     = 3'd3;
          end
        end
        default: begin
          if (key >= KEY_F1 && key <= KEY_F12) begin
            s.data[0] = CH_ESC;
            if (f < 4'd4) begin
              s.data[1] = CH_O;
              s.data[2] = CH_P + {4'd0, f};
              s.len     = 3'd3;
            end else begin
              s.data[1] = CH_LBRK;
              s.data[2] = fkey_hi(3'(f - 4'd4));
              s.data[3] = fkey_lo(3'(f - 4'd4));
              s.data[4] = CH_TILDE;
              s.len     = 3'd5;
            end
          end
        end
      endcase
    end
    encode = s;
  endfunction

  assign key_i.ready = !full_i;
  assign seq_o       = encode(key_i.key_code, key_i.shift_held, key_i.ctrl_held,
                              key_i.alt_held);
  // drop keys that produce no bytes
  assign push_o      = key_i.valid && !full_i && (seq_o.len != '0);

endmodule

[design/kese_queue.sv]
// Short descriptor queue between front and back end.
// Depends on kese_pkg.
module kese_queue
  import kese_pkg::*;
#(
  parameter int unsigned Depth = KESE_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  seq_t push_seq_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output seq_t pop_seq_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  seq_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign pop_seq_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_seq_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");
`endif

endmodule

[design/kese_back.sv]
// Back end: shifts a sequence descriptor out one byte per transfer.
// Depends on kese_pkg and kese_if; drains kese_queue.
module kese_back
  import kese_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  seq_t         seq_i,
  output logic         pop_o,
  kese_byte_if.source  byte_o
);

  logic [KESE_MAX_BYTES-1:0][7:0] data_q, data_d;
  seq_len_t                       rem_q, rem_d;
  logic                           xfer;

  assign byte_o.valid     = (rem_q != '0);
  assign byte_o.out_byte  = data_q[0];
  assign byte_o.last_byte = (rem_q == seq_len_t'(1));

  assign xfer  = byte_o.valid && byte_o.ready;
  // load when idle or when the last byte leaves
  assign pop_o = !empty_i && ((rem_q == '0) || (xfer && byte_o.last_byte));

  always_comb begin
    data_d = data_q;
    rem_d  = rem_q;
    if (pop_o) begin
      data_d = seq_i.data;
      rem_d  = seq_i.len;
    end else if (xfer) begin
      data_d = data_q >> 8;
      rem_d  = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

`ifndef ASSERT_OFF
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= seq_len_t'(KESE_MAX_BYTES)) else $error("byte count out of range");
  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> byte_o.valid) else $error("loaded an empty sequence");
`endif

endmodule
